[hdl/assert_macros.svh]
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MKE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define MKE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define MKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MKE_ASSERT(lbl, clk, rst_n, prop)
`define MKE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/mke_pkg.sv]
`default_nettype none

package mke_pkg;

	localparam int CHAR_W     = 8;
	localparam int DUR_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int SYM_MAX    = 6;
	localparam int SYM_CNT_W  = 3;
	localparam int STEP_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOT_ON     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_ON    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ELEM_GAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 3'd4;

	localparam logic [DUR_W-1:0] RST_DOT_ON     = 8'd6;
	localparam logic [DUR_W-1:0] RST_DASH_ON    = 8'd18;
	localparam logic [DUR_W-1:0] RST_ELEM_GAP   = 8'd6;
	localparam logic [DUR_W-1:0] RST_WORD_SPACE = 8'd16;
	localparam logic [DUR_W-1:0] RST_LETTER_GAP = 8'd24;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	typedef logic [STEP_W-1:0] step_t;

	// microprogram addresses
	localparam step_t ST_WAIT       = 3'd0;
	localparam step_t ST_TEST_ELEM  = 3'd1;
	localparam step_t ST_ON         = 3'd2;
	localparam step_t ST_GAP        = 3'd3;
	localparam step_t ST_TEST_SPACE = 3'd4;
	localparam step_t ST_SPACE      = 3'd5;
	localparam step_t ST_LETTER     = 3'd6;

	typedef struct packed {
		logic [DUR_W-1:0] dot_on;
		logic [DUR_W-1:0] dash_on;
		logic [DUR_W-1:0] elem_gap;
		logic [DUR_W-1:0] word_space;
		logic [DUR_W-1:0] letter_gap;
	} cfg_t;

	// symbol pattern, first element in the top bit, 1 = dah
	typedef struct packed {
		logic [SYM_CNT_W-1:0] len;
		logic [SYM_MAX-1:0]   bits;
	} sym_t;

	typedef enum logic [1:0] {
		DUR_ON     = 2'd0,
		DUR_GAP    = 2'd1,
		DUR_WORD   = 2'd2,
		DUR_LETTER = 2'd3
	} dur_sel_t;

	typedef enum logic [2:0] {
		COND_ALWAYS = 3'd0,
		COND_ACCEPT = 3'd1,
		COND_ELEM   = 3'd2,
		COND_MORE   = 3'd3,
		COND_SPACE  = 3'd4
	} cond_t;

	typedef struct packed {
		logic     load;
		logic     emit;
		logic     key;
		logic     last;
		dur_sel_t dur_sel;
		logic     shift;
		cond_t    cond;
		step_t    jump;
		step_t    nxt;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic elem_left;
		logic more_elem;
		logic is_space;
		logic out_free;
	} stat_t;

	// control store: branch to jump when cond holds, else to nxt
	function automatic ctl_t useq_rom(step_t s);
		ctl_t w;
		w.load    = 1'b0;
		w.emit    = 1'b0;
		w.key     = 1'b0;
		w.last    = 1'b0;
		w.dur_sel = DUR_GAP;
		w.shift   = 1'b0;
		w.cond    = COND_ALWAYS;
		w.jump    = ST_WAIT;
		w.nxt     = ST_WAIT;
		unique case (s)
			ST_WAIT: begin
				w.load = 1'b1;
				w.cond = COND_ACCEPT;
				w.jump = ST_TEST_ELEM;
				w.nxt  = ST_WAIT;
			end
			ST_TEST_ELEM: begin
				w.cond = COND_ELEM;
				w.jump = ST_ON;
				w.nxt  = ST_TEST_SPACE;
			end
			ST_ON: begin
				w.emit    = 1'b1;
				w.key     = 1'b1;
				w.dur_sel = DUR_ON;
				w.jump    = ST_GAP;
			end
			ST_GAP: begin
				w.emit    = 1'b1;
				w.dur_sel = DUR_GAP;
				w.shift   = 1'b1;
				w.cond    = COND_MORE;
				w.jump    = ST_ON;
				w.nxt     = ST_TEST_SPACE;
			end
			ST_TEST_SPACE: begin
				w.cond = COND_SPACE;
				w.jump = ST_SPACE;
				w.nxt  = ST_LETTER;
			end
			ST_SPACE: begin
				w.emit    = 1'b1;
				w.dur_sel = DUR_WORD;
				w.jump    = ST_LETTER;
			end
			ST_LETTER: begin
				w.emit    = 1'b1;
				w.last    = 1'b1;
				w.dur_sel = DUR_LETTER;
				w.jump    = ST_WAIT;
			end
			default: begin
				w.jump = ST_WAIT;
			end
		endcase
		return w;
	endfunction

	function automatic sym_t sym_lookup(logic [CHAR_W-1:0] ch);
		sym_t s;
		s.len  = 3'd0;
		s.bits = 6'b000000;
		unique case (ch)
			8'h41: s = '{3'd2, 6'b010000}; // A .-
			8'h42: s = '{3'd4, 6'b100000}; // B -...
			8'h43: s = '{3'd4, 6'b101000}; // C -.-.
			8'h44: s = '{3'd3, 6'b100000}; // D -..
			8'h45: s = '{3'd1, 6'b000000}; // E .
			8'h46: s = '{3'd4, 6'b001000}; // F ..-.
			8'h47: s = '{3'd3, 6'b110000}; // G --.
			8'h48: s = '{3'd4, 6'b000000}; // H ....
			8'h49: s = '{3'd2, 6'b000000}; // I ..
			8'h4A: s = '{3'd4, 6'b011100}; // J .---
			8'h4B: s = '{3'd3, 6'b101000}; // K -.-
			8'h4C: s = '{3'd4, 6'b010000}; // L .-..
			8'h4D: s = '{3'd2, 6'b110000}; // M --
			8'h4E: s = '{3'd2, 6'b100000}; // N -.
			8'h4F: s = '{3'd3, 6'b111000}; // O ---
			8'h50: s = '{3'd4, 6'b011000}; // P .--.
			8'h51: s = '{3'd4, 6'b110100}; // Q --.-
			8'h52: s = '{3'd3, 6'b010000}; // R .-.
			8'h53: s = '{3'd3, 6'b000000}; // S ...
			8'h54: s = '{3'd1, 6'b100000}; // T -
			8'h55: s = '{3'd3, 6'b001000}; // U ..-
			8'h56: s = '{3'd4, 6'b000100}; // V ...-
			8'h57: s = '{3'd3, 6'b011000}; // W .--
			8'h58: s = '{3'd4, 6'b100100}; // X -..-
			8'h59: s = '{3'd4, 6'b101100}; // Y -.--
			8'h5A: s = '{3'd4, 6'b110000}; // Z --..
			8'h30: s = '{3'd5, 6'b111110}; // 0
			8'h31: s = '{3'd5, 6'b011110}; // 1
			8'h32: s = '{3'd5, 6'b001110}; // 2
			8'h33: s = '{3'd5, 6'b000110}; // 3
			8'h34: s = '{3'd5, 6'b000010}; // 4
			8'h35: s = '{3'd5, 6'b000000}; // 5
			8'h36: s = '{3'd5, 6'b100000}; // 6
			8'h37: s = '{3'd5, 6'b110000}; // 7
			8'h38: s = '{3'd5, 6'b111000}; // 8
			8'h39: s = '{3'd5, 6'b111100}; // 9
			8'h2E: s = '{3'd6, 6'b010101}; // period .-.-.-
			default: s = '{3'd0, 6'b000000};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[hdl/mke_channels_if.sv]
`default_nettype none

interface mke_char_if;
	logic                          valid;
	logic                          ready;
	logic [mke_pkg::CHAR_W-1:0]    char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface mke_seg_if;
	logic                          valid;
	logic                          ready;
	logic                          key_down;
	logic [mke_pkg::DUR_W-1:0]     duration_ticks;
	logic                          last_of_char;

	modport source (output valid, output key_down, output duration_ticks,
		output last_of_char, input ready);
	modport sink   (input valid, input key_down, input duration_ticks,
		input last_of_char, output ready);
endinterface

interface mke_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mke_pkg::CFG_IDX_W-1:0]   reg_index;
	logic [mke_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[hdl/morse_keying_encoder_unit.sv]
// After a character is accepted, the element-test step leads to the first key-down step,
// whose beat is registered for the output; a space or a code without elements goes via the
// space-test step instead. A new character is accepted only back in the wait step, after
// the letter gap beat of the previous one; the sequencer takes one microprogram step per
// cycle unless a stalled output beat holds it on its emitting step.
// Reset: step counter to the wait step, output register empty, timing registers
// to 6/18/6/16/24 ticks.
`default_nettype none

`include "assert_macros.svh"

module morse_keying_encoder_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mke_char_if.sink   chars,
	mke_seg_if.source  segs,
	mke_cfg_if.sink    cfg
);

	mke_pkg::cfg_t  regs;
	mke_pkg::ctl_t  ctl;
	mke_pkg::stat_t stat;
	logic           go;

	mke_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mke_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.go     (go)
	);

	mke_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.segs   (segs),
		.regs   (regs),
		.ctl    (ctl),
		.go     (go),
		.stat   (stat)
	);

	// after a character beat the sequencer leaves the wait step
	`MKE_ASSERT_NEXT(a_leave_wait, clk, arst_n, chars.valid && chars.ready, !ctl.load)
	// a key-down segment needs a pending element
	`MKE_ASSERT_IMP(a_on_has_elem, clk, arst_n, go && ctl.emit && ctl.key, stat.elem_left)
	// the element count never underflows on a gap step
	`MKE_ASSERT_IMP(a_gap_has_elem, clk, arst_n, go && ctl.shift, stat.elem_left)

endmodule

`default_nettype wire

[hdl/mke_cfg_regs.sv]
`default_nettype none

module mke_cfg_regs (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mke_cfg_if.sink        cfg,
	output mke_pkg::cfg_t  regs
);

	mke_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dot_on     <= mke_pkg::RST_DOT_ON;
			regs_q.dash_on    <= mke_pkg::RST_DASH_ON;
			regs_q.elem_gap   <= mke_pkg::RST_ELEM_GAP;
			regs_q.word_space <= mke_pkg::RST_WORD_SPACE;
			regs_q.letter_gap <= mke_pkg::RST_LETTER_GAP;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				mke_pkg::REG_DOT_ON:     regs_q.dot_on     <= cfg.wdata;
				mke_pkg::REG_DASH_ON:    regs_q.dash_on    <= cfg.wdata;
				mke_pkg::REG_ELEM_GAP:   regs_q.elem_gap   <= cfg.wdata;
				mke_pkg::REG_WORD_SPACE: regs_q.word_space <= cfg.wdata;
				mke_pkg::REG_LETTER_GAP: regs_q.letter_gap <= cfg.wdata;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/mke_useq.sv]
`default_nettype none

module mke_useq (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  mke_pkg::stat_t  stat,
	output mke_pkg::ctl_t   ctl,
	output logic            go
);

	mke_pkg::step_t step_q;
	logic           cond_true;

	assign ctl = mke_pkg::useq_rom(step_q);

	always_comb begin
		unique case (ctl.cond)
			mke_pkg::COND_ALWAYS: cond_true = 1'b1;
			mke_pkg::COND_ACCEPT: cond_true = stat.in_valid;
			mke_pkg::COND_ELEM:   cond_true = stat.elem_left;
			mke_pkg::COND_MORE:   cond_true = stat.more_elem;
			mke_pkg::COND_SPACE:  cond_true = stat.is_space;
			default:              cond_true = 1'b1;
		endcase
	end

	// an emitting step holds until the output register can take the beat
	assign go = !(ctl.emit && !stat.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mke_pkg::ST_WAIT;
		end else if (go) begin
			step_q <= cond_true ? ctl.jump : ctl.nxt;
		end
	end

endmodule

`default_nettype wire

[hdl/mke_datapath.sv]
`default_nettype none

module mke_datapath (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mke_char_if.sink        chars,
	mke_seg_if.source       segs,
	input  mke_pkg::cfg_t   regs,
	input  mke_pkg::ctl_t   ctl,
	input  wire logic       go,
	output mke_pkg::stat_t  stat
);

	logic [mke_pkg::SYM_MAX-1:0]   pat_q;
	logic [mke_pkg::SYM_CNT_W-1:0] cnt_q;
	logic                          space_q;
	logic                          out_valid_q;
	logic                          key_q;
	logic [mke_pkg::DUR_W-1:0]     dur_q;
	logic                          last_q;

	mke_pkg::sym_t                 sym;
	logic [mke_pkg::DUR_W-1:0]     dur_sel;
	logic                          accept;
	logic                          out_free;

	assign sym      = mke_pkg::sym_lookup(chars.char_code);
	assign accept   = ctl.load && chars.valid;
	assign out_free = !out_valid_q || segs.ready;

	assign chars.ready = ctl.load;

	always_comb begin
		unique case (ctl.dur_sel)
			mke_pkg::DUR_ON:     dur_sel = pat_q[mke_pkg::SYM_MAX-1] ? regs.dash_on
				: regs.dot_on;
			mke_pkg::DUR_GAP:    dur_sel = regs.elem_gap;
			mke_pkg::DUR_WORD:   dur_sel = regs.word_space;
			mke_pkg::DUR_LETTER: dur_sel = regs.letter_gap;
			default:             dur_sel = regs.letter_gap;
		endcase
	end

	always_comb begin
		stat.in_valid  = chars.valid;
		stat.elem_left = (cnt_q != '0);
		stat.more_elem = (cnt_q > 3'd1);
		stat.is_space  = space_q;
		stat.out_free  = out_free;
	end

	// element shifter and count
	always_ff @(posedge clk) begin
		if (accept) begin
			pat_q   <= sym.bits;
			cnt_q   <= sym.len;
			space_q <= (chars.char_code == mke_pkg::CHAR_SPACE);
		end else if (go && ctl.shift) begin
			pat_q <= {pat_q[mke_pkg::SYM_MAX-2:0], 1'b0};
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (segs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.emit) begin
			key_q  <= ctl.key;
			dur_q  <= dur_sel;
			last_q <= ctl.last;
		end
	end

	assign segs.valid          = out_valid_q;
	assign segs.key_down       = key_q;
	assign segs.duration_ticks = dur_q;
	assign segs.last_of_char   = last_q;

endmodule

`default_nettype wire
